// File: rtl/bsl_pkg.sv
// Shared types and constants for the bounded sorted list engine.
// No dependencies; imported by bsl_cell, bsl_pick and the top level.
package bsl_pkg;

  localparam int KEY_W    = 32;
  localparam int DATA_W   = 32;
  localparam int WORD_W   = KEY_W + DATA_W;
  localparam int MODE_W   = 3;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 8;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INS_FRONT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_INS_BACK  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REM_FRONT = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REM_BACK  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_REM_KEY   = 3'd5;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISS  = 2'd3;

  // What a cell loads at the next edge
  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_LOAD = 2'd1,
    OP_UP   = 2'd2,
    OP_DOWN = 2'd3
  } cell_op_t;

  // Compare results a cell reports against the request key
  typedef struct packed {
    logic match;
    logic ge;
  } cell_flags_t;

endpackage

// File: rtl/bsl_cell.sv
// One list position: holds a key/data word and compares its key.
// Depends on bsl_pkg for word widths, cell_op_t and cell_flags_t.
module bsl_cell (
  input  logic                          clk,
  input  bsl_pkg::cell_op_t             op,
  input  logic [bsl_pkg::WORD_W-1:0]    new_word,
  input  logic [bsl_pkg::WORD_W-1:0]    lo_word,
  input  logic [bsl_pkg::WORD_W-1:0]    hi_word,
  input  logic [bsl_pkg::KEY_W-1:0]     rkey,
  output logic [bsl_pkg::WORD_W-1:0]    word,
  output bsl_pkg::cell_flags_t          flags
);
  import bsl_pkg::*;

  logic [KEY_W-1:0] own_key;

  // Load from the request, take the lower or upper neighbor, or hold
  always_ff @(posedge clk) begin
    unique case (op)
      OP_LOAD: word <= new_word;
      OP_UP:   word <= lo_word;
      OP_DOWN: word <= hi_word;
      OP_HOLD: word <= word;
      default: word <= word;
    endcase
  end

  // Compare stored key against the request key
  assign own_key     = word[WORD_W-1:DATA_W];
  assign flags.match = (own_key == rkey);
  assign flags.ge    = (own_key >= rkey);

endmodule

// File: rtl/bsl_pick.sv
// Two-level registered one-hot selector that reads a word out of the cell row.
// Depends on bsl_pkg for the word width.
module bsl_pick #(
  parameter int N = 128
) (
  input  logic                        clk,
  input  logic [N-1:0]                sel,
  input  logic [bsl_pkg::WORD_W-1:0]  words [N],
  output logic [bsl_pkg::WORD_W-1:0]  picked
);
  import bsl_pkg::*;

  localparam int GS = 16;
  localparam int NG = (N + GS - 1) / GS;

  logic [WORD_W-1:0] grp [NG];

  // First level: OR the selected word of each group into a register
  for (genvar g = 0; g < NG; g++) begin : g_grp
    logic [WORD_W-1:0] part [GS];
    logic [WORD_W-1:0] acc;

    for (genvar k = 0; k < GS; k++) begin : g_lane
      localparam int IDX = g * GS + k;
      if (IDX < N) begin : g_used
        assign part[k] = words[IDX] & {WORD_W{sel[IDX]}};
      end else begin : g_pad
        assign part[k] = '0;
      end
    end

    always_comb begin
      acc = '0;
      for (int k = 0; k < GS; k++) begin
        acc = acc | part[k];
      end
    end

    always_ff @(posedge clk) begin
      grp[g] <= acc;
    end
  end

  // Second level: OR the group registers
  always_comb begin
    picked = '0;
    for (int g = 0; g < NG; g++) begin
      picked = picked | grp[g];
    end
  end

endmodule

// File: rtl/bounded_sorted_list_engine.sv
// Bounded ordered key/data list built as a row of shifting cells.
// Request flow, with the result queued once the result port is free:
// clear, inserts, remove front and any request on an empty list go straight to done; remove back
// reads through the registered read selector first; remove by key scans, reads, then removes
// matching entries one at a time as the cells shift down, or goes to done when the key is missing.
// Reset clears the fill count and control; cell contents are not cleared.
module bounded_sorted_list_engine #(
  parameter int CAPACITY = 128
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  logic [bsl_pkg::MODE_W-1:0]     mode,
  input  logic [bsl_pkg::KEY_W-1:0]      key,
  input  logic [bsl_pkg::DATA_W-1:0]     data,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output logic [bsl_pkg::STATUS_W-1:0]   status,
  output logic [bsl_pkg::KEY_W-1:0]      out_key,
  output logic [bsl_pkg::DATA_W-1:0]     out_data,
  output logic [bsl_pkg::CNT_W-1:0]      removed_count,
  output logic [bsl_pkg::CNT_W-1:0]      fill_level
);
  import bsl_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > CNT_W) ? CW : CNT_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_PICK1 = 7'b0000100,
    S_PICK2 = 7'b0001000,
    S_RUN   = 7'b0010000,
    S_TAIL  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  typedef enum logic [1:0] {
    K_RUN  = 2'd0,
    K_TAIL = 2'd1,
    K_POP  = 2'd2
  } kind_t;

  state_t                state;
  kind_t                 kind;
  logic [CW-1:0]         count;
  logic [CW-1:0]         removed;
  logic [KEY_W-1:0]      rkey;
  logic [STATUS_W-1:0]   status_r;
  logic [WORD_W-1:0]     got;
  logic [CAPACITY-1:0]   reg_r;
  logic [CAPACITY-1:0]   sel_r;

  logic [WORD_W-1:0]     new_word;
  logic [WORD_W-1:0]     cell_word [CAPACITY];
  cell_flags_t           flags [CAPACITY];
  logic [WORD_W-1:0]     picked;

  wire  [CAPACITY-1:0]   valid;
  wire  [CAPACITY-1:0]   match_v;
  wire  [CAPACITY-1:0]   ge_v;
  wire  [CAPACITY-1:0]   last;
  wire  [CAPACITY-1:0]   after;
  wire  [CAPACITY-1:0]   head_mid;
  wire  [CAPACITY-1:0]   head_r;
  wire  [CAPACITY-1:0]   tail;
  wire  [CAPACITY-1:0]   tail_start;

  logic accept;
  logic full;
  logic front_hit;
  logic tail_hit;
  logic mid_hit;
  logic run_hit;
  logic do_ins_front;
  logic do_ins_back;
  logic do_pop_front;
  logic do_run_shift;

  function automatic logic [CNT_W-1:0] sat8(input logic [CW-1:0] v);
    logic [XW-1:0] w;
    w = XW'(v);
    sat8 = (w > XW'(255)) ? CNT_W'(255) : w[CNT_W-1:0];
  endfunction

  assign req_stall = rst || (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign new_word  = {key, data};
  assign full      = (count == CW'(CAPACITY));

  // Cell commands shared by the whole row
  assign do_ins_front = accept && (mode == MODE_INS_FRONT) && !full;
  assign do_ins_back  = accept && (mode == MODE_INS_BACK) && !full;
  assign do_pop_front = accept && (mode == MODE_REM_FRONT) && (count != '0);
  assign do_run_shift = (state == S_RUN) && run_hit;

  // Row-wide hit flags
  assign front_hit = match_v[0];
  assign tail_hit  = |(last & match_v);
  assign mid_hit   = |(head_mid & match_v);
  assign run_hit   = |(head_r & match_v);

  // Cell row with per-position occupancy, run and boundary flags
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_W-1:0] lo_word;
    logic [WORD_W-1:0] hi_word;
    cell_op_t          op;

    assign valid[i]   = (CW'(i) < count);
    assign match_v[i] = valid[i] & flags[i].match;
    assign ge_v[i]    = valid[i] & flags[i].ge;

    if (i == 0) begin : g_first
      assign lo_word       = new_word;
      assign after[i]      = ge_v[i];
      assign head_mid[i]   = after[i];
      assign head_r[i]     = reg_r[i];
      assign tail_start[i] = tail[i];
    end else begin : g_rest
      assign lo_word       = cell_word[i-1];
      assign after[i]      = after[i-1] | ge_v[i];
      assign head_mid[i]   = after[i] & ~after[i-1];
      assign head_r[i]     = reg_r[i] & ~reg_r[i-1];
      assign tail_start[i] = tail[i] & ~tail[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign hi_word = cell_word[i];
      assign last[i] = valid[i];
      assign tail[i] = match_v[i];
    end else begin : g_inner
      assign hi_word = cell_word[i+1];
      assign last[i] = valid[i] & ~valid[i+1];
      assign tail[i] = match_v[i] & (last[i] | tail[i+1]);
    end

    // Pick this cell's command
    always_comb begin
      priority if (do_ins_front) begin
        op = (i == 0) ? OP_LOAD : OP_UP;
      end else if (do_ins_back && (CW'(i) == count)) begin
        op = OP_LOAD;
      end else if (do_pop_front || (do_run_shift && reg_r[i])) begin
        op = OP_DOWN;
      end else begin
        op = OP_HOLD;
      end
    end

    bsl_cell u_cell (
      .clk      (clk),
      .op       (op),
      .new_word (new_word),
      .lo_word  (lo_word),
      .hi_word  (hi_word),
      .rkey     (rkey),
      .word     (cell_word[i]),
      .flags    (flags[i])
    );
  end

  // Read out the word at the selected position
  bsl_pick #(
    .N (CAPACITY)
  ) u_pick (
    .clk    (clk),
    .sel    (sel_r),
    .words  (cell_word),
    .picked (picked)
  );

  // Request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // Drop the result word once taken, unless a new one replaces it
      if (rsp_valid && !rsp_stall && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            rkey <= key;
            unique case (mode)
              MODE_CLEAR: begin
                removed  <= count;
                got      <= '0;
                status_r <= ST_OK;
                count    <= '0;
                state    <= S_DONE;
              end
              MODE_INS_FRONT, MODE_INS_BACK: begin
                removed <= '0;
                got     <= '0;
                state   <= S_DONE;
                if (full) begin
                  status_r <= ST_FULL;
                end else begin
                  status_r <= ST_OK;
                  count    <= count + CW'(1);
                end
              end
              MODE_REM_FRONT: begin
                state <= S_DONE;
                if (count == '0) begin
                  status_r <= ST_EMPTY;
                  got      <= '0;
                  removed  <= '0;
                end else begin
                  status_r <= ST_OK;
                  got      <= cell_word[0];
                  count    <= count - CW'(1);
                  removed  <= CW'(1);
                end
              end
              MODE_REM_BACK: begin
                removed <= '0;
                got     <= '0;
                if (count == '0) begin
                  status_r <= ST_EMPTY;
                  state    <= S_DONE;
                end else begin
                  status_r <= ST_OK;
                  sel_r    <= last;
                  kind     <= K_POP;
                  state    <= S_PICK1;
                end
              end
              MODE_REM_KEY: begin
                removed <= '0;
                got     <= '0;
                if (count == '0) begin
                  status_r <= ST_EMPTY;
                  state    <= S_DONE;
                end else begin
                  status_r <= ST_OK;
                  state    <= S_SCAN;
                end
              end
              default: begin
                removed  <= '0;
                got      <= '0;
                status_r <= ST_OK;
                state    <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          priority if (front_hit) begin
            reg_r <= '1;
            sel_r <= CAPACITY'(1);
            kind  <= K_RUN;
            state <= S_PICK1;
          end else if (tail_hit) begin
            sel_r <= tail_start;
            kind  <= K_TAIL;
            state <= S_PICK1;
          end else if (mid_hit) begin
            reg_r <= after;
            sel_r <= head_mid;
            kind  <= K_RUN;
            state <= S_PICK1;
          end else begin
            status_r <= ST_MISS;
            state    <= S_DONE;
          end
        end
        S_PICK1: begin
          state <= S_PICK2;
        end
        S_PICK2: begin
          got <= picked;
          unique case (kind)
            K_RUN:  state <= S_RUN;
            K_TAIL: state <= S_TAIL;
            K_POP: begin
              count   <= count - CW'(1);
              removed <= CW'(1);
              state   <= S_DONE;
            end
            default: state <= S_DONE;
          endcase
        end
        // Drop the head of the region while it still matches
        S_RUN: begin
          if (run_hit) begin
            count   <= count - CW'(1);
            removed <= removed + CW'(1);
          end else begin
            state <= S_DONE;
          end
        end
        // Drop matching entries off the back
        S_TAIL: begin
          if (tail_hit) begin
            count   <= count - CW'(1);
            removed <= removed + CW'(1);
          end else begin
            state <= S_DONE;
          end
        end
        // Queue the result word once the output register is free
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result register fields
  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!rsp_valid || !rsp_stall)) begin
      status        <= status_r;
      out_key       <= got[WORD_W-1:DATA_W];
      out_data      <= got[DATA_W-1:0];
      removed_count <= sat8(removed);
      fill_level    <= sat8(count);
    end
  end

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("sequencer stayed idle after taking a request");

  a_run_shrinks: assert property (@(posedge clk) disable iff (rst)
    ((state == S_RUN) && run_hit) |=> (count == $past(count) - CW'(1)))
    else $error("run removal did not shrink the list");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_DONE))
    else $error("result raised outside the done state");

  a_sel_onehot: assert property (@(posedge clk) disable iff (rst)
    (state == S_PICK1) |-> $onehot(sel_r))
    else $error("read selector is not one-hot");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> (count <= CW'(CAPACITY)))
    else $error("fill count beyond capacity");

endmodule

// File: test/tb_bounded_sorted_list_engine.sv
// Self-checking testbench for bounded_sorted_list_engine: a directed table, then random
// request sequences with idling on both sides, checked against a list model kept here.
// Depends on rtl/bsl_pkg.sv and rtl/bounded_sorted_list_engine.sv.
module tb_bounded_sorted_list_engine;
  import bsl_pkg::*;

  localparam int LIST_DEPTH      = 128;
  localparam int WORD_TARGET     = 1150;
  localparam int PHASE_WORDS     = 120;
  localparam int PRESSURE_CYCLES = 400;
  localparam int TAIL_CYCLES     = 200;
  localparam int LIMIT_CYCLES    = 1000000;
  localparam int SHOWN_MAX       = 60;

  // Modes the block leaves alone
  localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    key;
    logic [DATA_W-1:0]   data;
    logic [CNT_W-1:0]    removed;
    logic [CNT_W-1:0]    fill;
  } list_result_t;

  typedef struct {
    logic [MODE_W-1:0]   mode;
    logic [KEY_W-1:0]    key;
    logic [DATA_W-1:0]   data;
    bit                  typed;
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    okey;
    logic [DATA_W-1:0]   odata;
    logic [CNT_W-1:0]    removed;
    logic [CNT_W-1:0]    fill;
  } script_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_stall;
  logic [MODE_W-1:0]   mode = MODE_CLEAR;
  logic [KEY_W-1:0]    key = '0;
  logic [DATA_W-1:0]   data = '0;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [KEY_W-1:0]    out_key;
  logic [DATA_W-1:0]   out_data;
  logic [CNT_W-1:0]    removed_count;
  logic [CNT_W-1:0]    fill_level;

  // List contents as the block should hold them
  logic [WORD_W-1:0] shadow_slots [LIST_DEPTH];
  int                shadow_count = 0;

  list_result_t predicted_outcomes [$];
  list_result_t want;
  list_result_t row_want;
  int           errors = 0;
  int           shown_errors = 0;
  int           words_sent = 0;
  int           idle_pct = 0;
  int           stall_pct = 0;
  bit           pressure_go = 1'b0;
  bit           pressure_done = 1'b0;
  int           hold_left = 0;
  int           cycle_count = 0;
  int           seq_pick;

  // Directed requests; typed rows carry their expected result in the table, the others take it from the list model
  script_row_t directed_script [25] = '{
    '{MODE_REM_FRONT, 32'h0, 32'h0, 1'b1, ST_EMPTY, 32'h0, 32'h0, 8'd0, 8'd0},
    '{MODE_REM_BACK, 32'h0, 32'h0, 1'b1, ST_EMPTY, 32'h0, 32'h0, 8'd0, 8'd0},
    '{MODE_REM_KEY, 32'h0, 32'h0, 1'b1, ST_EMPTY, 32'h0, 32'h0, 8'd0, 8'd0},
    '{MODE_CLEAR, 32'h0, 32'h0, 1'b1, ST_OK, 32'h0, 32'h0, 8'd0, 8'd0},
    '{MODE_SPARE6, 32'h0, 32'h0, 1'b1, ST_OK, 32'h0, 32'h0, 8'd0, 8'd0},
    '{MODE_SPARE7, 32'hffffffff, 32'hffffffff, 1'b1, ST_OK, 32'h0, 32'h0, 8'd0, 8'd0},
    '{MODE_INS_BACK, 32'h0, 32'h0, 1'b1, ST_OK, 32'h0, 32'h0, 8'd0, 8'd1},
    '{MODE_INS_FRONT, 32'hffffffff, 32'hffffffff, 1'b1, ST_OK, 32'h0, 32'h0, 8'd0, 8'd2},
    '{MODE_INS_BACK, 32'h5, 32'h55, 1'b1, ST_OK, 32'h0, 32'h0, 8'd0, 8'd3},
    '{MODE_INS_BACK, 32'h5, 32'h56, 1'b1, ST_OK, 32'h0, 32'h0, 8'd0, 8'd4},
    '{MODE_INS_BACK, 32'h9, 32'h99, 1'b1, ST_OK, 32'h0, 32'h0, 8'd0, 8'd5},
    '{MODE_REM_KEY, 32'h7, 32'h0, 1'b1, ST_MISS, 32'h0, 32'h0, 8'd0, 8'd5},
    '{MODE_REM_KEY, 32'h0, 32'h0, 1'b0, ST_OK, 32'h0, 32'h0, 8'd0, 8'd0},
    '{MODE_SPARE6, 32'h12345678, 32'hffffffff, 1'b0, ST_OK, 32'h0, 32'h0, 8'd0, 8'd0},
    '{MODE_REM_FRONT, 32'h0, 32'h0, 1'b1, ST_OK, 32'hffffffff, 32'hffffffff, 8'd1, 8'd4},
    '{MODE_REM_KEY, 32'h5, 32'h0, 1'b0, ST_OK, 32'h0, 32'h0, 8'd0, 8'd0},
    '{MODE_REM_KEY, 32'h9, 32'h0, 1'b0, ST_OK, 32'h0, 32'h0, 8'd0, 8'd0},
    '{MODE_REM_BACK, 32'h0, 32'h0, 1'b0, ST_OK, 32'h0, 32'h0, 8'd0, 8'd0},
    '{MODE_INS_BACK, 32'h3, 32'ha1, 1'b0, ST_OK, 32'h0, 32'h0, 8'd0, 8'd0},
    '{MODE_INS_BACK, 32'h3, 32'ha2, 1'b0, ST_OK, 32'h0, 32'h0, 8'd0, 8'd0},
    '{MODE_INS_FRONT, 32'h3, 32'ha0, 1'b0, ST_OK, 32'h0, 32'h0, 8'd0, 8'd0},
    '{MODE_REM_KEY, 32'h3, 32'h0, 1'b0, ST_OK, 32'h0, 32'h0, 8'd0, 8'd0},
    '{MODE_INS_FRONT, 32'h1, 32'h11, 1'b0, ST_OK, 32'h0, 32'h0, 8'd0, 8'd0},
    '{MODE_INS_FRONT, 32'h2, 32'h22, 1'b0, ST_OK, 32'h0, 32'h0, 8'd0, 8'd0},
    '{MODE_CLEAR, 32'h0, 32'h0, 1'b1, ST_OK, 32'h0, 32'h0, 8'd2, 8'd0}
  };

  bounded_sorted_list_engine #(
    .CAPACITY(LIST_DEPTH)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .mode          (mode),
    .key           (key),
    .data          (data),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .status        (status),
    .out_key       (out_key),
    .out_data      (out_data),
    .removed_count (removed_count),
    .fill_level    (fill_level)
  );

  always #10 clk = ~clk;

  function automatic logic [KEY_W-1:0] key_of_slot(input int pos);
    return shadow_slots[pos][WORD_W-1:DATA_W];
  endfunction

  // Apply one request to the list copy and return the result it must produce
  function automatic list_result_t apply_list_request(input logic [MODE_W-1:0] m,
                                                      input logic [KEY_W-1:0] k,
                                                      input logic [DATA_W-1:0] d);
    list_result_t      r;
    logic [WORD_W-1:0] taken;
    bit                took;
    int                n, i, j;
    r = '0;
    r.status = ST_OK;
    taken = '0;
    took = 1'b0;
    n = shadow_count;
    case (m)
      MODE_CLEAR: begin
        r.removed = CNT_W'(n);
        shadow_count = 0;
      end
      MODE_INS_FRONT, MODE_INS_BACK: begin
        if (n >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (m == MODE_INS_FRONT) begin
            for (i = n; i > 0; i--) shadow_slots[i] = shadow_slots[i-1];
            shadow_slots[0] = {k, d};
          end else begin
            shadow_slots[n] = {k, d};
          end
          shadow_count = n + 1;
        end
      end
      MODE_REM_FRONT, MODE_REM_BACK: begin
        if (n == 0) begin
          r.status = ST_EMPTY;
        end else begin
          took = 1'b1;
          r.removed = 8'd1;
          if (m == MODE_REM_FRONT) begin
            taken = shadow_slots[0];
            for (i = 1; i < n; i++) shadow_slots[i-1] = shadow_slots[i];
          end else begin
            taken = shadow_slots[n-1];
          end
          shadow_count = n - 1;
        end
      end
      MODE_REM_KEY: begin
        if (n == 0) begin
          r.status = ST_EMPTY;
        end else if (key_of_slot(0) == k) begin
          // drop the matching run at the front
          j = 0;
          while (j < n && key_of_slot(j) == k) j++;
          taken = shadow_slots[0];
          took = 1'b1;
          for (i = j; i < n; i++) shadow_slots[i-j] = shadow_slots[i];
          r.removed = CNT_W'(j);
          shadow_count = n - j;
        end else if (key_of_slot(n-1) == k) begin
          // drop the matching run at the back
          i = n;
          while (i > 0 && key_of_slot(i-1) == k) i--;
          taken = shadow_slots[i];
          took = 1'b1;
          r.removed = CNT_W'(n - i);
          shadow_count = i;
        end else begin
          // skip smaller keys, then compact out the equal run found there
          i = 0;
          while (i < n && k > key_of_slot(i)) i++;
          j = i;
          while (j < n && key_of_slot(j) == k) j++;
          if (j == i) begin
            r.status = ST_MISS;
          end else begin
            taken = shadow_slots[i];
            took = 1'b1;
            r.removed = CNT_W'(j - i);
            shadow_count = n - (j - i);
            for (; j < n; j++, i++) shadow_slots[i] = shadow_slots[j];
          end
        end
      end
      default: ;
    endcase
    if (took) {r.key, r.data} = taken;
    r.fill = CNT_W'(shadow_count);
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    int c;
    c = $urandom_range(0, 99);
    if (c < 70) return KEY_W'($urandom_range(0, 15));
    if (c < 80) return $urandom_range(0, 1) ? '1 : '0;
    return $urandom();
  endfunction

  // Mostly a key that is in the list, so removals find something
  function automatic logic [KEY_W-1:0] pick_removal_key();
    if (shadow_count > 0 && $urandom_range(0, 99) < 70)
      return key_of_slot($urandom_range(0, shadow_count - 1));
    return pick_key();
  endfunction

  // Offer one request word, wait for it to be taken, record what it must return
  task automatic offer(input logic [MODE_W-1:0] m, input logic [KEY_W-1:0] k,
                       input logic [DATA_W-1:0] d, input bit typed,
                       input list_result_t typed_res);
    list_result_t got;
    case ((words_sent / PHASE_WORDS) % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 58; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 58; end
      default: begin idle_pct = 32; stall_pct = 32; end
    endcase
    while ($urandom_range(0, 99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    mode <= m;
    key <= k;
    data <= d;
    do @(posedge clk); while (req_stall);
    got = apply_list_request(m, k, d);
    predicted_outcomes.push_back(typed ? typed_res : got);
    if (m <= MODE_REM_KEY) words_sent++;
  endtask

  function automatic logic [MODE_W-1:0] pick_insert_mode();
    return $urandom_range(0, 1) ? MODE_INS_FRONT : MODE_INS_BACK;
  endfunction

  // Fill to capacity, push against the full list, then empty it again
  task automatic run_fill_sequence(input bit one_key);
    logic [KEY_W-1:0] k;
    k = pick_key();
    while (shadow_count < LIST_DEPTH)
      offer(pick_insert_mode(), one_key ? k : pick_key(), $urandom(), 1'b0, '0);
    repeat (3) offer(pick_insert_mode(), pick_key(), $urandom(), 1'b0, '0);
    if (one_key) begin
      offer(MODE_REM_KEY, k, $urandom(), 1'b0, '0);
    end else begin
      repeat (12) offer(MODE_REM_KEY, pick_removal_key(), $urandom(), 1'b0, '0);
    end
    offer(MODE_CLEAR, $urandom(), $urandom(), 1'b0, '0);
  endtask

  // Ascending keys with repeats, then removals that hit runs inside the list
  task automatic run_sorted_sequence();
    logic [KEY_W-1:0] k;
    if ($urandom_range(0, 1)) offer(MODE_CLEAR, $urandom(), $urandom(), 1'b0, '0);
    k = $urandom_range(0, 1) ? KEY_W'($urandom_range(0, 20)) : KEY_W'($urandom());
    repeat ($urandom_range(4, 30)) begin
      offer(MODE_INS_BACK, k, $urandom(), 1'b0, '0);
      k = k + KEY_W'($urandom_range(0, 2));
    end
    repeat ($urandom_range(3, 8)) begin
      if ($urandom_range(0, 99) < 25)
        offer(MODE_REM_KEY, pick_key(), $urandom(), 1'b0, '0);
      else
        offer(MODE_REM_KEY, pick_removal_key(), $urandom(), 1'b0, '0);
    end
  endtask

  // Weighted mix of all modes, leaning toward growth or shrinkage
  task automatic run_mixed_burst();
    int                c;
    bit                grow;
    logic [MODE_W-1:0] m;
    grow = $urandom_range(0, 1);
    repeat ($urandom_range(10, 40)) begin
      c = $urandom_range(0, 99);
      if (c < 2) m = MODE_CLEAR;
      else if (c < 4) m = $urandom_range(0, 1) ? MODE_SPARE6 : MODE_SPARE7;
      else if (c < (grow ? 64 : 30)) m = pick_insert_mode();
      else if (c < (grow ? 84 : 65)) m = $urandom_range(0, 1) ? MODE_REM_FRONT : MODE_REM_BACK;
      else m = MODE_REM_KEY;
      offer(m, (m == MODE_REM_KEY) ? pick_removal_key() : pick_key(), $urandom(), 1'b0, '0);
    end
  endtask

  // Any mode, any key and data
  task automatic run_noise();
    repeat ($urandom_range(5, 15))
      offer(MODE_W'($urandom_range(0, 7)), $urandom(), $urandom(), 1'b0, '0);
  endtask

  task automatic check_field(input string what, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      if (shown_errors < SHOWN_MAX) begin
        shown_errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
      end
    end
  endtask

  // Check each result word taken, then pick the stall for the next cycle
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (predicted_outcomes.size() == 0) begin
        errors++;
        if (shown_errors < SHOWN_MAX) begin
          shown_errors++;
          $display("%0t: unexpected result word, expected none, actual key %0h", $time,
                   out_key);
        end
      end else begin
        want = predicted_outcomes.pop_front();
        check_field("status", want.status, status);
        check_field("out_key", want.key, out_key);
        check_field("out_data", want.data, out_data);
        check_field("removed_count", want.removed, removed_count);
        check_field("fill_level", want.fill, fill_level);
      end
    end
    if (pressure_go && !pressure_done) begin
      hold_left = PRESSURE_CYCLES;
      pressure_done = 1'b1;
    end
    if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left--;
    end else begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (directed_script[r]) begin
      row_want.status  = directed_script[r].status;
      row_want.key     = directed_script[r].okey;
      row_want.data    = directed_script[r].odata;
      row_want.removed = directed_script[r].removed;
      row_want.fill    = directed_script[r].fill;
      offer(directed_script[r].mode, directed_script[r].key, directed_script[r].data,
            directed_script[r].typed, row_want);
    end

    // Hold off the result side at the start of the first fill, then fill with a single key
    pressure_go = 1'b1;
    run_fill_sequence(1'b0);
    run_fill_sequence(1'b1);

    while (words_sent < WORD_TARGET) begin
      seq_pick = $urandom_range(0, 99);
      if (seq_pick < 45) run_mixed_burst();
      else if (seq_pick < 75) run_sorted_sequence();
      else if (seq_pick < 90) run_noise();
      else if (seq_pick < 93) run_fill_sequence($urandom_range(0, 1));
      else run_mixed_burst();
    end
    req_valid <= 1'b0;

    // Drain, then watch for stray results
    while (predicted_outcomes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: bounded_sorted_list_engine.f
rtl/bsl_pkg.sv
rtl/bsl_cell.sv
rtl/bsl_pick.sv
rtl/bounded_sorted_list_engine.sv
test/tb_bounded_sorted_list_engine.sv
